// ===== sv/wror_pkg.sv =====
// Package for the windowed rate-of-rise block: field widths, unit codes,
// register indexes, sequencer states and arithmetic constants.
// No dependencies; imported by windowed_rate_of_rise_top.
`default_nettype none

package wror_pkg;

	localparam int WINDOW_DEPTH_DEF = 60;
	localparam int RISE_WIDTH_DEF   = 24;

	localparam int TIME_W    = 32;
	localparam int HUND_W    = 17;
	localparam int TEMP_W    = 19;
	localparam int CORR_W    = 15;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 72;  // 66 payload bits rounded up to whole bytes
	localparam int USER_W    = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_BT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_ET = 2'd2;

	typedef enum logic [1:0] {
		UNIT_C = 2'd0,
		UNIT_F = 2'd1,
		UNIT_K = 2'd2
	} unit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CONV,
		ST_STORE,
		ST_DIFF,
		ST_DIV,
		ST_SAT,
		ST_OUT
	} state_t;

	// floor(h * 9 / 5) = (h * 9 * ceil(2^26 / 5)) >> 26, exact for 17-bit h.
	localparam int                 DIV5_SHIFT = 26;
	localparam logic [26:0]        MUL9_DIV5  = 27'd120795957;
	localparam int                 PROD_W     = HUND_W + 27;
	localparam int                 FAHR_W     = 18;
	localparam logic signed [19:0] F_OFFSET   = 20'sd3200;
	localparam logic signed [19:0] K_OFFSET   = 20'sd27315;

	// Rate: positive temperature difference times 60000 over elapsed ms.
	localparam int          DIFF_W     = TEMP_W;
	localparam logic [15:0] RATE_SCALE = 16'd60000;
	localparam int          NUM_W      = DIFF_W + 16;

endpackage

`default_nettype wire

// ===== sv/windowed_rate_of_rise_top.sv =====
// Sequence: a fill tick (first after reset or a register write) runs MUL, CONV, STORE, OUT;
// a later tick runs MUL, CONV, STORE, DIFF, DIV, SAT, OUT; OUT waits for a free output.
// A new item is taken only in IDLE, once the last result is in the output register; DIV is
// the 35-step serial divider that both channels run side by side.
// Reset: asynchronous, active low; clears the configuration and control registers, held rates and the history flag.
// The window RAM needs no clearing pass: a fill count marks the entries written since fill.
`default_nettype none

module windowed_rate_of_rise_top #(
	parameter int WINDOW_DEPTH = wror_pkg::WINDOW_DEPTH_DEF,
	parameter int RISE_WIDTH   = wror_pkg::RISE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// time_ms[31:0], bt_hundredths[48:32], et_hundredths[65:49], zero fill above
	input  wire logic [wror_pkg::IN_W-1:0]      s_axis_tdata,
	// bt_fault[0], et_fault[1]
	input  wire logic [wror_pkg::USER_W-1:0]    s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// bt_temp[18:0], et_temp[37:19], bt_rise, et_rise, zero fill to whole bytes
	output logic [((38 + 2*RISE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// bt_valid[0], et_valid[1]
	output logic [wror_pkg::USER_W-1:0]         m_axis_tuser,
	input  wire logic                           cfg_we,
	input  wire logic [wror_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wror_pkg::CFG_W-1:0]     cfg_data
);
	import wror_pkg::*;

	localparam int OUT_W  = ((38 + 2*RISE_WIDTH + 7) / 8) * 8;
	localparam int IW     = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int MEM_W  = TIME_W + 2*TEMP_W;
	localparam int STEP_W = $clog2(NUM_W);
	localparam int SAT_W  = (NUM_W > RISE_WIDTH) ? NUM_W : RISE_WIDTH;

	localparam logic [IW-1:0]     LAST_SLOT  = IW'(WINDOW_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(WINDOW_DEPTH);
	localparam logic [SAT_W-1:0]  RISE_MAX   = SAT_W'({RISE_WIDTH{1'b1}});
	localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NUM_W - 1);

	// Configuration registers.
	unit_t                    unit_q;
	logic signed [CORR_W-1:0] corr_bt_q;
	logic signed [CORR_W-1:0] corr_et_q;

	state_t state_q, state_d;

	// Input item and converted temperatures.
	logic [TIME_W-1:0]        t_q;
	logic [HUND_W-1:0]        bh_q, eh_q;
	logic                     bv_q, ev_q;
	logic [PROD_W-1:0]        prod_bt_s1, prod_et_s1;
	logic signed [TEMP_W-1:0] bt_q, et_q;

	// Window bookkeeping.
	logic                     hist_q;
	logic [IW-1:0]            slot_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     old_mem_q;
	logic [TIME_W-1:0]        fill_t_q;
	logic signed [TEMP_W-1:0] fill_bt_q, fill_et_q;
	logic signed [TEMP_W-1:0] newest_bt_q, newest_et_q;

	// Divider.
	logic [NUM_W-1:0]         num_bt_q, num_et_q;
	logic [TIME_W-1:0]        rem_bt_q, rem_et_q;
	logic [TIME_W-1:0]        dvs_q;
	logic [STEP_W-1:0]        step_q;
	logic                     do_bt_q, do_et_q;
	logic [RISE_WIDTH-1:0]    held_bt_q, held_et_q;

	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;
	logic [USER_W-1:0]        out_user_q;

	// RAM port.
	logic                     mem_we;
	logic [IW-1:0]            mem_waddr, mem_raddr;
	logic [MEM_W-1:0]         mem_wdata, mem_rdata;

	logic                     in_xfer, out_free, cfg_hit;
	logic [IW-1:0]            old_idx;
	logic signed [TEMP_W-1:0] bt_w, et_w, bt_conv, et_conv;
	logic signed [TEMP_W-1:0] old_bt, old_et;
	logic [TIME_W-1:0]        old_t, dt;
	logic signed [TEMP_W:0]   diff_bt, diff_et;
	logic [NUM_W-1:0]         num_bt_n, num_et_n;
	logic [TIME_W-1:0]        rem_bt_n, rem_et_n;

	function automatic logic signed [TEMP_W-1:0] convert(
		input unit_t                    u,
		input logic [HUND_W-1:0]        h,
		input logic [FAHR_W-1:0]        f,
		input logic signed [CORR_W-1:0] corr
	);
		logic signed [TEMP_W:0] base;
		logic signed [TEMP_W:0] sum;
		unique case (u)
			UNIT_F:  base = $signed({2'b00, f}) + F_OFFSET;
			UNIT_K:  base = $signed({3'b000, h}) + K_OFFSET;
			default: base = $signed({3'b000, h});
		endcase
		sum = base + {{(TEMP_W + 1 - CORR_W){corr[CORR_W-1]}}, corr};
		return sum[TEMP_W-1:0];
	endfunction

	// One restoring division step: shifts a quotient bit into num.
	function automatic logic [NUM_W+TIME_W-1:0] div_step(
		input logic [NUM_W-1:0]  num,
		input logic [TIME_W-1:0] rem,
		input logic [TIME_W-1:0] dvs
	);
		logic [TIME_W:0] rs;
		logic            ge;
		rs = {rem, num[NUM_W-1]};
		ge = rs >= {1'b0, dvs};
		if (ge) begin
			rs = rs - {1'b0, dvs};
		end
		return {num[NUM_W-2:0], ge, rs[TIME_W-1:0]};
	endfunction

	function automatic logic [RISE_WIDTH-1:0] saturate(input logic [NUM_W-1:0] q);
		logic [SAT_W-1:0] qx;
		qx = SAT_W'(q);
		return (qx > RISE_MAX) ? RISE_MAX[RISE_WIDTH-1:0] : qx[RISE_WIDTH-1:0];
	endfunction

	wror_ram #(
		.WIDTH(MEM_W),
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cfg_hit  = cfg_we && (cfg_index == REG_UNIT_MODE || cfg_index == REG_CORRECTION_BT
		|| cfg_index == REG_CORRECTION_ET);
	assign old_idx  = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;

	assign bt_conv = convert(unit_q, bh_q, prod_bt_s1[DIV5_SHIFT +: FAHR_W], corr_bt_q);
	assign et_conv = convert(unit_q, eh_q, prod_et_s1[DIV5_SHIFT +: FAHR_W], corr_et_q);

	// An invalid channel repeats the newest window entry.
	assign bt_w = bv_q ? bt_q : newest_bt_q;
	assign et_w = ev_q ? et_q : newest_et_q;

	// Entries not yet written since the fill still hold the fill values.
	assign old_t   = old_mem_q ? mem_rdata[MEM_W-1 -: TIME_W] : fill_t_q;
	assign old_bt  = old_mem_q ? $signed(mem_rdata[2*TEMP_W-1 -: TEMP_W]) : fill_bt_q;
	assign old_et  = old_mem_q ? $signed(mem_rdata[TEMP_W-1:0]) : fill_et_q;
	assign dt      = t_q - old_t;
	assign diff_bt = {bt_q[TEMP_W-1], bt_q} - {old_bt[TEMP_W-1], old_bt};
	assign diff_et = {et_q[TEMP_W-1], et_q} - {old_et[TEMP_W-1], old_et};

	assign {num_bt_n, rem_bt_n} = div_step(num_bt_q, rem_bt_q, dvs_q);
	assign {num_et_n, rem_et_n} = div_step(num_et_q, rem_et_q, dvs_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_xfer) state_d = ST_MUL;
			ST_MUL:   state_d = ST_CONV;
			ST_CONV:  state_d = ST_STORE;
			ST_STORE: state_d = hist_q ? ST_DIFF : ST_OUT;
			ST_DIFF:  state_d = ST_DIV;
			ST_DIV:   if (step_q == '0) state_d = ST_SAT;
			ST_SAT:   state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		mem_we        = (state_q == ST_STORE) && hist_q;
		mem_waddr     = slot_q;
		mem_raddr     = old_idx;
		mem_wdata     = {t_q, bt_w, et_w};
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			unit_q      <= UNIT_C;
			corr_bt_q   <= '0;
			corr_et_q   <= '0;
			hist_q      <= 1'b0;
			slot_q      <= '0;
			cnt_q       <= '0;
			held_bt_q   <= '0;
			held_et_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_STORE) begin
				if (!hist_q) begin
					hist_q <= 1'b1;
					slot_q <= '0;
					cnt_q  <= '0;
				end else begin
					slot_q <= old_idx;
					if (cnt_q != FULL_CNT) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			if (state_q == ST_SAT) begin
				held_bt_q <= do_bt_q ? saturate(num_bt_q) : '0;
				held_et_q <= do_et_q ? saturate(num_et_q) : '0;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_UNIT_MODE:     unit_q    <= unit_t'(cfg_data[1:0]);
					REG_CORRECTION_BT: corr_bt_q <= $signed(cfg_data);
					REG_CORRECTION_ET: corr_et_q <= $signed(cfg_data);
					default:           ;
				endcase
			end
			if (cfg_hit) begin
				hist_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			t_q  <= s_axis_tdata[TIME_W-1:0];
			bh_q <= s_axis_tdata[TIME_W +: HUND_W];
			eh_q <= s_axis_tdata[TIME_W+HUND_W +: HUND_W];
			bv_q <= !s_axis_tuser[0] && (s_axis_tdata[TIME_W +: HUND_W] != '0);
			ev_q <= !s_axis_tuser[1] && (s_axis_tdata[TIME_W+HUND_W +: HUND_W] != '0);
		end
		if (state_q == ST_MUL) begin
			prod_bt_s1 <= PROD_W'(bh_q) * PROD_W'(MUL9_DIV5);
			prod_et_s1 <= PROD_W'(eh_q) * PROD_W'(MUL9_DIV5);
		end
		if (state_q == ST_CONV) begin
			bt_q <= bv_q ? bt_conv : '0;
			et_q <= ev_q ? et_conv : '0;
		end
		if (state_q == ST_STORE) begin
			if (!hist_q) begin
				fill_t_q    <= t_q;
				fill_bt_q   <= bt_q;
				fill_et_q   <= et_q;
				newest_bt_q <= bt_q;
				newest_et_q <= et_q;
			end else begin
				newest_bt_q <= bt_w;
				newest_et_q <= et_w;
				old_mem_q   <= CNT_W'(old_idx) <= cnt_q;
			end
		end
		if (state_q == ST_DIFF) begin
			num_bt_q <= NUM_W'(diff_bt[DIFF_W-1:0]) * NUM_W'(RATE_SCALE);
			num_et_q <= NUM_W'(diff_et[DIFF_W-1:0]) * NUM_W'(RATE_SCALE);
			rem_bt_q <= '0;
			rem_et_q <= '0;
			dvs_q    <= dt;
			step_q   <= LAST_STEP;
			do_bt_q  <= bv_q && (bt_q > old_bt) && (dt != '0);
			do_et_q  <= ev_q && (et_q > old_et) && (dt != '0);
		end
		if (state_q == ST_DIV) begin
			num_bt_q <= num_bt_n;
			num_et_q <= num_et_n;
			rem_bt_q <= rem_bt_n;
			rem_et_q <= rem_et_n;
			step_q   <= step_q - 1'b1;
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= OUT_W'({held_et_q, held_bt_q, et_q, bt_q});
			out_user_q <= {ev_q, bv_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr != mem_raddr))
		else $error("window write and read address the same entry");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= FULL_CNT) && (slot_q <= LAST_SLOT))
		else $error("window fill count or slot out of range");

	a_fill_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE && !hist_q) |=> (cnt_q == '0 && slot_q == '0))
		else $error("fill tick did not restart the window");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAT && !bv_q) |=> (held_bt_q == '0))
		else $error("invalid bean reading left a nonzero rate");

endmodule

`default_nettype wire

// ===== sv/wror_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`default_nettype none

module wror_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
